// ===== sv/rss_pkg.sv =====
// robot safety supervisor: shared types, codes and constants
// used by every module of the block; depends on nothing
`default_nettype none
package rss_pkg;

  localparam int TIME_BITS = 32;
  localparam int VAL_BITS  = 32;
  localparam int DIST_BITS = 20;
  localparam int TMO_BITS  = 24;
  localparam int POS_BITS  = 24;
  localparam int SPD_BITS  = 21;

  localparam int EVQ_DEPTH = 4;
  localparam int EVQ_AW    = $clog2(EVQ_DEPTH);
  localparam int EVQ_CW    = $clog2(EVQ_DEPTH + 1);

  typedef logic [TIME_BITS-1:0] time_t;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_SCENE = 2'd1,
    OP_CMD   = 2'd2,
    OP_CHECK = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    EV_COMM  = 3'd0,
    EV_EMERG = 3'd1,
    EV_LANE  = 3'd2,
    EV_STUCK = 3'd3,
    EV_CLEAR = 3'd4
  } event_kind_t;

  localparam logic [1:0] SEV_INFO = 2'd0;
  localparam logic [1:0] SEV_WARN = 2'd1;
  localparam logic [1:0] SEV_CRIT = 2'd2;

  localparam logic [1:0] CFG_EMERG_DIST = 2'd0;
  localparam logic [1:0] CFG_STUCK_TMO  = 2'd1;
  localparam logic [1:0] CFG_LANE_TMO   = 2'd2;
  localparam logic [1:0] CFG_SCENE_TMO  = 2'd3;

  // bit positions in an event mask, in emission order
  localparam int EVB_COMM  = 0;
  localparam int EVB_EMERG = 1;
  localparam int EVB_LANE  = 2;
  localparam int EVB_STUCK = 3;
  localparam int EVB_CLEAR = 4;
  localparam int EVB_NUM   = 5;

  // movement threshold in mm, compared on the squared distance
  localparam int MOVE_MM = 5;

  typedef struct packed {
    logic [DIST_BITS-1:0] emergency_distance;
    logic [TMO_BITS-1:0]  stuck_timeout;
    logic [TMO_BITS-1:0]  lane_timeout;
    logic [TMO_BITS-1:0]  scene_timeout;
  } cfg_t;

  typedef struct packed {
    op_t                       op;
    logic                      scene_is_empty;
    logic                      opponent_detected;
    logic [DIST_BITS-1:0]      opponent_distance;
    logic                      lane_is_lost;
    logic signed [POS_BITS-1:0] pose_x;
    logic signed [POS_BITS-1:0] pose_y;
    logic signed [SPD_BITS-1:0] linear_speed;
    logic signed [SPD_BITS-1:0] turn_rate;
  } item_t;

  // all events of one check, emitted lowest mask bit first
  typedef struct packed {
    logic [EVB_NUM-1:0]   mask;
    time_t                age;
    logic [DIST_BITS-1:0] opp_mm;
    time_t                dur;
    time_t                stall;
  } bundle_t;

  function automatic logic [5:0] sq3(input logic [2:0] v);
    sq3 = 6'(v) * 6'(v);
  endfunction

endpackage
`default_nettype wire

// ===== sv/rss_core.sv =====
// robot safety supervisor: supervisor state and check evaluation
// depends on rss_pkg
`default_nettype none
module rss_core (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire rss_pkg::cfg_t   cfg,
  input  wire rss_pkg::item_t  item,
  input  wire logic            adv,
  output rss_pkg::bundle_t     bundle
);

  localparam int DW = rss_pkg::POS_BITS + 1;

  rss_pkg::time_t time_now_r, time_now_nxt;
  rss_pkg::time_t scene_stamp_r, scene_stamp_nxt;
  rss_pkg::time_t pose_change_stamp_r, pose_change_stamp_nxt;
  rss_pkg::time_t lane_loss_stamp_r, lane_loss_stamp_nxt;
  logic scene_seen_r, scene_seen_nxt;
  logic scene_empty_r, scene_empty_nxt;
  logic opp_det_r, opp_det_nxt;
  logic [rss_pkg::DIST_BITS-1:0] opp_dist_r, opp_dist_nxt;
  logic lane_gone_r, lane_gone_nxt;
  logic signed [rss_pkg::POS_BITS-1:0] pose_x_r, pose_x_nxt, pose_y_r, pose_y_nxt;
  logic signed [rss_pkg::POS_BITS-1:0] prev_x_r, prev_x_nxt, prev_y_r, prev_y_nxt;
  logic prev_valid_r, prev_valid_nxt;
  logic cmd_seen_r, cmd_seen_nxt;
  logic cmd_moving_r, cmd_moving_nxt;
  logic lane_active_r, lane_active_nxt;
  logic alert_r, alert_nxt;

  logic signed [rss_pkg::POS_BITS-1:0] px, py;
  logic signed [DW-1:0] dx, dy;
  logic [DW-1:0] adx, ady;
  logic moved;
  rss_pkg::time_t age, dur, stall;
  logic [rss_pkg::EVB_NUM-1:0] mask;

  function automatic rss_pkg::time_t scene_timeout_ext();
    scene_timeout_ext = rss_pkg::time_t'(cfg.scene_timeout);
  endfunction
  function automatic rss_pkg::time_t lane_timeout_ext();
    lane_timeout_ext = rss_pkg::time_t'(cfg.lane_timeout);
  endfunction
  function automatic rss_pkg::time_t stuck_timeout_ext();
    stuck_timeout_ext = rss_pkg::time_t'(cfg.stuck_timeout);
  endfunction

  always_comb begin
    px  = scene_empty_r ? '0 : pose_x_r;
    py  = scene_empty_r ? '0 : pose_y_r;
    dx  = DW'(px) - DW'(prev_x_r);
    dy  = DW'(py) - DW'(prev_y_r);
    adx = dx[DW-1] ? DW'(-dx) : DW'(dx);
    ady = dy[DW-1] ? DW'(-dy) : DW'(dy);
    moved = (adx > DW'(rss_pkg::MOVE_MM)) || (ady > DW'(rss_pkg::MOVE_MM)) ||
            (7'(rss_pkg::sq3(adx[2:0])) + 7'(rss_pkg::sq3(ady[2:0])) >
             7'(rss_pkg::MOVE_MM * rss_pkg::MOVE_MM));
    age   = time_now_r - scene_stamp_r;
    dur   = time_now_r - lane_loss_stamp_r;
    stall = time_now_r - pose_change_stamp_r;
  end

  always_comb begin
    mask = '0;
    if (scene_seen_r && age > scene_timeout_ext()) begin
      mask[rss_pkg::EVB_COMM] = 1'b1;
    end
    if (scene_seen_r && !scene_empty_r) begin
      if (opp_det_r && opp_dist_r < cfg.emergency_distance) begin
        mask[rss_pkg::EVB_EMERG] = 1'b1;
      end
      if (lane_gone_r && lane_active_r && dur > lane_timeout_ext()) begin
        mask[rss_pkg::EVB_LANE] = 1'b1;
      end
    end
    if (scene_seen_r && cmd_seen_r && cmd_moving_r && !(prev_valid_r && moved) &&
        stall > stuck_timeout_ext()) begin
      mask[rss_pkg::EVB_STUCK] = 1'b1;
    end
    if (mask == '0 && alert_r) begin
      mask[rss_pkg::EVB_CLEAR] = 1'b1;
    end
    bundle.mask   = mask;
    bundle.age    = age;
    bundle.opp_mm = opp_dist_r;
    bundle.dur    = dur;
    bundle.stall  = stall;
  end

  always_comb begin
    time_now_nxt          = time_now_r;
    scene_stamp_nxt       = scene_stamp_r;
    pose_change_stamp_nxt = pose_change_stamp_r;
    lane_loss_stamp_nxt   = lane_loss_stamp_r;
    scene_seen_nxt        = scene_seen_r;
    scene_empty_nxt       = scene_empty_r;
    opp_det_nxt           = opp_det_r;
    opp_dist_nxt          = opp_dist_r;
    lane_gone_nxt         = lane_gone_r;
    pose_x_nxt            = pose_x_r;
    pose_y_nxt            = pose_y_r;
    prev_x_nxt            = prev_x_r;
    prev_y_nxt            = prev_y_r;
    prev_valid_nxt        = prev_valid_r;
    cmd_seen_nxt          = cmd_seen_r;
    cmd_moving_nxt        = cmd_moving_r;
    lane_active_nxt       = lane_active_r;
    alert_nxt             = alert_r;
    case (item.op)
      rss_pkg::OP_TICK: begin
        time_now_nxt = time_now_r + 1'b1;
      end
      rss_pkg::OP_SCENE: begin
        scene_empty_nxt = item.scene_is_empty;
        opp_det_nxt     = item.opponent_detected;
        opp_dist_nxt    = item.opponent_distance;
        lane_gone_nxt   = item.lane_is_lost;
        pose_x_nxt      = item.pose_x;
        pose_y_nxt      = item.pose_y;
        scene_seen_nxt  = 1'b1;
        scene_stamp_nxt = time_now_r;
      end
      rss_pkg::OP_CMD: begin
        cmd_moving_nxt = (item.linear_speed > 21'sd1) || (item.linear_speed < -21'sd1) ||
                         (item.turn_rate > 21'sd10) || (item.turn_rate < -21'sd10);
        cmd_seen_nxt   = 1'b1;
      end
      rss_pkg::OP_CHECK: begin
        if (scene_seen_r && !scene_empty_r) begin
          if (lane_gone_r) begin
            if (!lane_active_r) begin
              lane_active_nxt     = 1'b1;
              lane_loss_stamp_nxt = time_now_r;
            end
          end else begin
            lane_active_nxt = 1'b0;
          end
        end
        if (scene_seen_r && cmd_seen_r) begin
          if (prev_valid_r && moved) begin
            pose_change_stamp_nxt = time_now_r;
          end
          prev_x_nxt     = px;
          prev_y_nxt     = py;
          prev_valid_nxt = 1'b1;
        end
        alert_nxt = (mask[rss_pkg::EVB_CLEAR-1:0] != '0);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_now_r          <= '0;
      scene_stamp_r       <= '0;
      pose_change_stamp_r <= '0;
      lane_loss_stamp_r   <= '0;
      scene_seen_r        <= 1'b0;
      scene_empty_r       <= 1'b0;
      opp_det_r           <= 1'b0;
      opp_dist_r          <= '0;
      lane_gone_r         <= 1'b0;
      pose_x_r            <= '0;
      pose_y_r            <= '0;
      prev_x_r            <= '0;
      prev_y_r            <= '0;
      prev_valid_r        <= 1'b0;
      cmd_seen_r          <= 1'b0;
      cmd_moving_r        <= 1'b0;
      lane_active_r       <= 1'b0;
      alert_r             <= 1'b0;
    end else if (adv) begin
      time_now_r          <= time_now_nxt;
      scene_stamp_r       <= scene_stamp_nxt;
      pose_change_stamp_r <= pose_change_stamp_nxt;
      lane_loss_stamp_r   <= lane_loss_stamp_nxt;
      scene_seen_r        <= scene_seen_nxt;
      scene_empty_r       <= scene_empty_nxt;
      opp_det_r           <= opp_det_nxt;
      opp_dist_r          <= opp_dist_nxt;
      lane_gone_r         <= lane_gone_nxt;
      pose_x_r            <= pose_x_nxt;
      pose_y_r            <= pose_y_nxt;
      prev_x_r            <= prev_x_nxt;
      prev_y_r            <= prev_y_nxt;
      prev_valid_r        <= prev_valid_nxt;
      cmd_seen_r          <= cmd_seen_nxt;
      cmd_moving_r        <= cmd_moving_nxt;
      lane_active_r       <= lane_active_nxt;
      alert_r             <= alert_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== sv/rss_evq.sv =====
// robot safety supervisor: queue of check bundles and event serializer
// depends on rss_pkg
`default_nettype none
module rss_evq (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    push,
  input  wire rss_pkg::bundle_t        push_bundle,
  output logic                         full,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [2:0]                   out_event_kind,
  output logic [1:0]                   out_severity_level,
  output logic [rss_pkg::VAL_BITS-1:0] out_measured_value,
  output logic                         out_last_event
);

  rss_pkg::bundle_t q_r [rss_pkg::EVQ_DEPTH];
  logic [rss_pkg::EVQ_AW-1:0] wr_r, rd_r;
  logic [rss_pkg::EVQ_CW-1:0] cnt_r, cnt_nxt;
  rss_pkg::bundle_t cur_r;
  logic [rss_pkg::EVB_NUM-1:0] cur_mask_r, cur_mask_nxt;
  logic [rss_pkg::EVB_NUM-1:0] low_bit;
  rss_pkg::event_kind_t kind;
  logic done, load;

  assign full      = (cnt_r == rss_pkg::EVQ_CW'(rss_pkg::EVQ_DEPTH));
  assign out_valid = (cur_mask_r != '0);
  assign low_bit   = cur_mask_r & (~cur_mask_r + 1'b1);
  assign done      = !out_valid || (out_ready && (cur_mask_r == low_bit));
  assign load      = done && (cnt_r != '0);

  always_comb begin
    if (cur_mask_r[rss_pkg::EVB_COMM]) begin
      kind = rss_pkg::EV_COMM;
    end else if (cur_mask_r[rss_pkg::EVB_EMERG]) begin
      kind = rss_pkg::EV_EMERG;
    end else if (cur_mask_r[rss_pkg::EVB_LANE]) begin
      kind = rss_pkg::EV_LANE;
    end else if (cur_mask_r[rss_pkg::EVB_STUCK]) begin
      kind = rss_pkg::EV_STUCK;
    end else begin
      kind = rss_pkg::EV_CLEAR;
    end
  end

  always_comb begin
    out_event_kind = kind;
    out_last_event = (cur_mask_r == low_bit);
    case (kind)
      rss_pkg::EV_COMM: begin
        out_severity_level = rss_pkg::SEV_CRIT;
        out_measured_value = rss_pkg::VAL_BITS'(cur_r.age);
      end
      rss_pkg::EV_EMERG: begin
        out_severity_level = rss_pkg::SEV_CRIT;
        out_measured_value = rss_pkg::VAL_BITS'(cur_r.opp_mm);
      end
      rss_pkg::EV_LANE: begin
        out_severity_level = rss_pkg::SEV_WARN;
        out_measured_value = rss_pkg::VAL_BITS'(cur_r.dur);
      end
      rss_pkg::EV_STUCK: begin
        out_severity_level = rss_pkg::SEV_WARN;
        out_measured_value = rss_pkg::VAL_BITS'(cur_r.stall);
      end
      default: begin
        out_severity_level = rss_pkg::SEV_INFO;
        out_measured_value = '0;
      end
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r + rss_pkg::EVQ_CW'(push) - rss_pkg::EVQ_CW'(load);
    if (load) begin
      cur_mask_nxt = q_r[rd_r].mask;
    end else if (done) begin
      cur_mask_nxt = '0;
    end else if (out_ready) begin
      cur_mask_nxt = cur_mask_r & ~low_bit;
    end else begin
      cur_mask_nxt = cur_mask_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_r] <= push_bundle;
    end
    if (load) begin
      cur_r <= q_r[rd_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r       <= '0;
      rd_r       <= '0;
      cnt_r      <= '0;
      cur_mask_r <= '0;
    end else begin
      if (push) begin
        wr_r <= wr_r + 1'b1;
      end
      if (load) begin
        rd_r <= rd_r + 1'b1;
      end
      cnt_r      <= cnt_nxt;
      cur_mask_r <= cur_mask_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== sv/robot_safety_supervisor.sv =====
// robot safety supervisor top level: input register, config registers,
// check evaluation (rss_core) and event output queue (rss_evq); uses rss_pkg
`default_nettype none
// Takes one item per cycle: ticks, scene reports, velocity commands and
// check requests. Every item passes through one input register and is
// evaluated there; a check that raises events stores them as one entry of
// a four-entry queue, and the output side hands them out one event per
// cycle while out_ready is high, in the order comm fail, emergency, lane
// lost, stuck (or a single clear), with last_event on the final one.
// Results pass the input register, the queue and the output register,
// and wait longer while earlier events are queued. Input is throttled
// only when the queue is full, i.e. the consumer takes fewer events per
// cycle than the checks produce. The user writes configuration through
// the cfg port, always ready, while no item is in flight; not enforced.
module robot_safety_supervisor (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [1:0]                       cfg_index,
  input  wire logic [rss_pkg::TMO_BITS-1:0]     cfg_data,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [1:0]                       in_operation,
  input  wire logic                             in_scene_is_empty,
  input  wire logic                             in_opponent_detected,
  input  wire logic [rss_pkg::DIST_BITS-1:0]    in_opponent_distance,
  input  wire logic                             in_lane_is_lost,
  input  wire logic signed [rss_pkg::POS_BITS-1:0] in_pose_x,
  input  wire logic signed [rss_pkg::POS_BITS-1:0] in_pose_y,
  input  wire logic signed [rss_pkg::SPD_BITS-1:0] in_linear_speed,
  input  wire logic signed [rss_pkg::SPD_BITS-1:0] in_turn_rate,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [2:0]                            out_event_kind,
  output logic [1:0]                            out_severity_level,
  output logic [rss_pkg::VAL_BITS-1:0]          out_measured_value,
  output logic                                  out_last_event
);

  rss_pkg::cfg_t    cfg_r;
  rss_pkg::item_t   item_r;
  logic             stage_v_r;
  logic             adv, full, push;
  rss_pkg::bundle_t bundle;

  assign cfg_ready = 1'b1;
  assign adv       = stage_v_r && ((item_r.op != rss_pkg::OP_CHECK) || !full);
  assign in_ready  = !stage_v_r || adv;
  assign push      = adv && (item_r.op == rss_pkg::OP_CHECK) && (bundle.mask != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.emergency_distance <= rss_pkg::DIST_BITS'(150);
      cfg_r.stuck_timeout      <= rss_pkg::TMO_BITS'(5000);
      cfg_r.lane_timeout       <= rss_pkg::TMO_BITS'(3000);
      cfg_r.scene_timeout      <= rss_pkg::TMO_BITS'(2000);
    end else if (cfg_valid) begin
      case (cfg_index)
        rss_pkg::CFG_EMERG_DIST: cfg_r.emergency_distance <= cfg_data[rss_pkg::DIST_BITS-1:0];
        rss_pkg::CFG_STUCK_TMO:  cfg_r.stuck_timeout      <= cfg_data;
        rss_pkg::CFG_LANE_TMO:   cfg_r.lane_timeout       <= cfg_data;
        rss_pkg::CFG_SCENE_TMO:  cfg_r.scene_timeout      <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_v_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      stage_v_r <= 1'b1;
    end else if (adv) begin
      stage_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.op                <= rss_pkg::op_t'(in_operation);
      item_r.scene_is_empty    <= in_scene_is_empty;
      item_r.opponent_detected <= in_opponent_detected;
      item_r.opponent_distance <= in_opponent_distance;
      item_r.lane_is_lost      <= in_lane_is_lost;
      item_r.pose_x            <= in_pose_x;
      item_r.pose_y            <= in_pose_y;
      item_r.linear_speed      <= in_linear_speed;
      item_r.turn_rate         <= in_turn_rate;
    end
  end

  rss_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .item   (item_r),
    .adv    (adv),
    .bundle (bundle)
  );

  rss_evq u_evq (
    .clk                (clk),
    .rst_n              (rst_n),
    .push               (push),
    .push_bundle        (bundle),
    .full               (full),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_event_kind     (out_event_kind),
    .out_severity_level (out_severity_level),
    .out_measured_value (out_measured_value),
    .out_last_event     (out_last_event)
  );

endmodule
`default_nettype wire

// ===== sv/rss_checker.sv =====
// robot safety supervisor: port-level checks on the event output
// bound to robot_safety_supervisor; uses rss_pkg
`default_nettype none
module rss_checker (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             out_valid,
  input  wire logic                             out_ready,
  input  wire logic [2:0]                       out_event_kind,
  input  wire logic [1:0]                       out_severity_level,
  input  wire logic [rss_pkg::VAL_BITS-1:0]     out_measured_value,
  input  wire logic                             out_last_event
);

  // no event right after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("event shown right after reset");

  // stalled event holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_event_kind) &&
    $stable(out_measured_value) && $stable(out_last_event))
    else $error("stalled event changed");

  // clear stands alone: info, zero value, last of its check
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_kind == rss_pkg::EV_CLEAR |->
    out_severity_level == rss_pkg::SEV_INFO && out_measured_value == '0 && out_last_event)
    else $error("malformed clear event");

  // comm fail and emergency are critical, the rest not; only the first two are checked
  a_sev: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_kind == rss_pkg::EV_COMM || out_event_kind == rss_pkg::EV_EMERG)
    |-> out_severity_level == rss_pkg::SEV_CRIT)
    else $error("critical event with wrong severity");

  // a check's events come in rising kind order until its last one
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_event |=> out_valid &&
    out_event_kind > $past(out_event_kind) && out_event_kind != rss_pkg::EV_CLEAR)
    else $error("events of a check out of order");

endmodule

bind robot_safety_supervisor rss_checker u_rss_checker (.*);
`default_nettype wire

// ===== test/robot_safety_supervisor_tb.sv =====
// testbench for robot_safety_supervisor: predicts the events of each check and
// compares them in order; random ticks, scenes, commands and checks under idling
// depends on rss_pkg and the robot_safety_supervisor rtl
`default_nettype none
module robot_safety_supervisor_tb;

  localparam int CYCLE_LIMIT = 200000;

  typedef struct {
    logic [2:0]  kind;
    logic [1:0]  sev;
    logic [31:0] val;
    logic        last;
  } safety_event_t;

  class event_scoreboard;
    logic [rss_pkg::DIST_BITS-1:0] emerg_dist;
    logic [rss_pkg::TMO_BITS-1:0]  stuck_tmo, lane_tmo, scene_tmo;
    logic [31:0] now, scene_at, pose_moved_at, lane_gone_at;
    bit have_scene, scene_empty, opp_seen, lane_gone, have_cmd, moving;
    bit prev_valid, lane_timing, alerted;
    logic [rss_pkg::DIST_BITS-1:0] opp_dist;
    longint pose_x, pose_y, prev_x, prev_y;
    safety_event_t awaited_events[$];
    int errors, items, checks, events, writes;

    function new();
      emerg_dist = 150;
      stuck_tmo = 5000;
      lane_tmo = 3000;
      scene_tmo = 2000;
      now = 0; scene_at = 0; pose_moved_at = 0; lane_gone_at = 0;
      have_scene = 0; scene_empty = 0; opp_seen = 0; lane_gone = 0;
      have_cmd = 0; moving = 0; prev_valid = 0; lane_timing = 0; alerted = 0;
      opp_dist = 0;
      pose_x = 0; pose_y = 0; prev_x = 0; prev_y = 0;
      errors = 0; items = 0; checks = 0; events = 0; writes = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [rss_pkg::TMO_BITS-1:0] data);
      writes++;
      case (idx)
        rss_pkg::CFG_EMERG_DIST: emerg_dist = data[rss_pkg::DIST_BITS-1:0];
        rss_pkg::CFG_STUCK_TMO:  stuck_tmo = data;
        rss_pkg::CFG_LANE_TMO:   lane_tmo = data;
        rss_pkg::CFG_SCENE_TMO:  scene_tmo = data;
        default: ;
      endcase
    endfunction

    function int pending_count();
      return awaited_events.size();
    endfunction

    function void take_item(rss_pkg::item_t it);
      safety_event_t found[$];
      safety_event_t ev;
      logic [31:0] age, dur, st;
      longint px, py, dx, dy, ls, tr;
      items++;
      case (it.op)
        rss_pkg::OP_TICK: now = now + 32'd1;
        rss_pkg::OP_SCENE: begin
          scene_empty = it.scene_is_empty;
          opp_seen = it.opponent_detected;
          opp_dist = it.opponent_distance;
          lane_gone = it.lane_is_lost;
          pose_x = longint'(it.pose_x);
          pose_y = longint'(it.pose_y);
          have_scene = 1;
          scene_at = now;
        end
        rss_pkg::OP_CMD: begin
          ls = longint'(it.linear_speed);
          tr = longint'(it.turn_rate);
          if (ls < 0) ls = -ls;
          if (tr < 0) tr = -tr;
          moving = (ls > 1) || (tr > 10);
          have_cmd = 1;
        end
        default: begin
          checks++;
          if (have_scene) begin
            age = now - scene_at;
            if (age > {8'd0, scene_tmo}) begin
              ev = '{rss_pkg::EV_COMM, rss_pkg::SEV_CRIT, age, 1'b0};
              found.insert(found.size(), ev);
            end
          end
          if (have_scene && !scene_empty) begin
            if (opp_seen && opp_dist < emerg_dist) begin
              ev = '{rss_pkg::EV_EMERG, rss_pkg::SEV_CRIT, {12'd0, opp_dist}, 1'b0};
              found.insert(found.size(), ev);
            end
            if (lane_gone) begin
              if (!lane_timing) begin
                lane_timing = 1;
                lane_gone_at = now;
              end else begin
                dur = now - lane_gone_at;
                if (dur > {8'd0, lane_tmo}) begin
                  ev = '{rss_pkg::EV_LANE, rss_pkg::SEV_WARN, dur, 1'b0};
                  found.insert(found.size(), ev);
                end
              end
            end else begin
              lane_timing = 0;
            end
          end
          if (have_scene && have_cmd) begin
            px = scene_empty ? 0 : pose_x;
            py = scene_empty ? 0 : pose_y;
            if (prev_valid) begin
              dx = px - prev_x;
              dy = py - prev_y;
              if (dx < 0) dx = -dx;
              if (dy < 0) dy = -dy;
              if (dx * dx + dy * dy > 25) pose_moved_at = now;
            end
            prev_x = px;
            prev_y = py;
            prev_valid = 1;
            if (moving) begin
              st = now - pose_moved_at;
              if (st > {8'd0, stuck_tmo}) begin
                ev = '{rss_pkg::EV_STUCK, rss_pkg::SEV_WARN, st, 1'b0};
                found.insert(found.size(), ev);
              end
            end
          end
          if (found.size() > 0) begin
            alerted = 1;
          end else if (alerted) begin
            ev = '{rss_pkg::EV_CLEAR, rss_pkg::SEV_INFO, 32'd0, 1'b0};
            found.insert(found.size(), ev);
            alerted = 0;
          end
          if (found.size() > 0) found[found.size()-1].last = 1'b1;
          foreach (found[i]) awaited_events.insert(awaited_events.size(), found[i]);
        end
      endcase
    endfunction

    task report(string what);
      errors++;
      $display("mismatch: %s", what);
    endtask

    task match_event(logic [2:0] kind, logic [1:0] sev, logic [31:0] val, logic last);
      safety_event_t want;
      events++;
      if (awaited_events.size() == 0) begin
        report($sformatf("event kind %0d sev %0d value %0d last %0d with none awaited",
                         kind, sev, val, last));
      end else begin
        want = awaited_events.pop_front();
        if (kind !== want.kind || sev !== want.sev || val !== want.val || last !== want.last)
          report($sformatf("got kind %0d sev %0d value %0d last %0d, want %0d %0d %0d %0d",
                           kind, sev, val, last, want.kind, want.sev, want.val, want.last));
      end
    endtask

    task leftover_check();
      if (awaited_events.size() != 0)
        report($sformatf("%0d events never arrived", awaited_events.size()));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_valid, cfg_ready;
  logic [1:0] cfg_index;
  logic [rss_pkg::TMO_BITS-1:0] cfg_data;
  logic in_valid, in_ready;
  logic [1:0] in_operation;
  logic in_scene_is_empty, in_opponent_detected, in_lane_is_lost;
  logic [rss_pkg::DIST_BITS-1:0] in_opponent_distance;
  logic signed [rss_pkg::POS_BITS-1:0] in_pose_x, in_pose_y;
  logic signed [rss_pkg::SPD_BITS-1:0] in_linear_speed, in_turn_rate;
  logic out_valid, out_ready;
  logic [2:0] out_event_kind;
  logic [1:0] out_severity_level;
  logic [rss_pkg::VAL_BITS-1:0] out_measured_value;
  logic out_last_event;

  robot_safety_supervisor dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_operation(in_operation),
    .in_scene_is_empty(in_scene_is_empty), .in_opponent_detected(in_opponent_detected),
    .in_opponent_distance(in_opponent_distance), .in_lane_is_lost(in_lane_is_lost),
    .in_pose_x(in_pose_x), .in_pose_y(in_pose_y),
    .in_linear_speed(in_linear_speed), .in_turn_rate(in_turn_rate),
    .out_valid(out_valid), .out_ready(out_ready), .out_event_kind(out_event_kind),
    .out_severity_level(out_severity_level), .out_measured_value(out_measured_value),
    .out_last_event(out_last_event)
  );

  event_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int cycle_count = 0;
  int hold_left = 0;
  bit hold_go = 0;
  bit hold_taken = 0;
  logic signed [rss_pkg::POS_BITS-1:0] walk_x = '0, walk_y = '0;
  bit lane_flag = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("TEST FAILED");
      $finish;
    end
  end

  // receiver: random stalls plus one long hold-off
  always @(negedge clk) begin
    if (hold_go && !hold_taken) begin
      hold_taken = 1;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready = 1'b0;
    end else begin
      out_ready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.match_event(out_event_kind, out_severity_level, out_measured_value, out_last_event);
  end

  function automatic rss_pkg::item_t item_of(rss_pkg::op_t op, bit empty, bit det, int dist_mm,
                                             bit lane, int x, int y, int ls, int tr);
    rss_pkg::item_t it;
    it.op = op;
    it.scene_is_empty = empty;
    it.opponent_detected = det;
    it.opponent_distance = rss_pkg::DIST_BITS'(dist_mm);
    it.lane_is_lost = lane;
    it.pose_x = rss_pkg::POS_BITS'(x);
    it.pose_y = rss_pkg::POS_BITS'(y);
    it.linear_speed = rss_pkg::SPD_BITS'(ls);
    it.turn_rate = rss_pkg::SPD_BITS'(tr);
    return it;
  endfunction

  function automatic rss_pkg::item_t random_item(int check_pct);
    rss_pkg::item_t it;
    int r, lim;
    it.op = rss_pkg::op_t'($urandom_range(3));
    it.scene_is_empty = 1'($urandom_range(1));
    it.opponent_detected = 1'($urandom_range(1));
    it.opponent_distance = rss_pkg::DIST_BITS'($urandom);
    it.lane_is_lost = 1'($urandom_range(1));
    it.pose_x = rss_pkg::POS_BITS'($urandom);
    it.pose_y = rss_pkg::POS_BITS'($urandom);
    it.linear_speed = rss_pkg::SPD_BITS'($urandom);
    it.turn_rate = rss_pkg::SPD_BITS'($urandom);
    if ($urandom_range(99) < 10) return it;
    r = $urandom_range(99);
    if (r < check_pct) begin
      it.op = rss_pkg::OP_CHECK;
    end else begin
      r = $urandom_range(99);
      it.op = (r < 55) ? rss_pkg::OP_TICK : (r < 80) ? rss_pkg::OP_SCENE : rss_pkg::OP_CMD;
    end
    case (it.op)
      rss_pkg::OP_SCENE: begin
        it.scene_is_empty = ($urandom_range(99) < 12);
        it.opponent_detected = ($urandom_range(99) < 60);
        r = $urandom_range(99);
        lim = int'(sb.emerg_dist) + 2;
        if (lim > 1048575) lim = 1048575;
        if (r < 50) it.opponent_distance = rss_pkg::DIST_BITS'($urandom_range(lim));
        else if (r < 65) it.opponent_distance = 20'd999000;
        if ($urandom_range(99) < 25) lane_flag = !lane_flag;
        it.lane_is_lost = lane_flag;
        r = $urandom_range(99);
        if (r < 70) begin
          walk_x = walk_x + rss_pkg::POS_BITS'($urandom_range(12)) - 24'sd6;
          walk_y = walk_y + rss_pkg::POS_BITS'($urandom_range(12)) - 24'sd6;
        end else if (r < 80) begin
          walk_x = rss_pkg::POS_BITS'($urandom);
          walk_y = rss_pkg::POS_BITS'($urandom);
        end
        it.pose_x = walk_x;
        it.pose_y = walk_y;
      end
      rss_pkg::OP_CMD: begin
        r = $urandom_range(99);
        if (r < 20) begin
          it.linear_speed = '0;
          it.turn_rate = '0;
        end else if (r < 70) begin
          it.linear_speed = rss_pkg::SPD_BITS'($urandom_range(6)) - 21'sd3;
          it.turn_rate = rss_pkg::SPD_BITS'($urandom_range(30)) - 21'sd15;
        end
      end
      default: ;
    endcase
    return it;
  endfunction

  task automatic send_item(rss_pkg::item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_operation = it.op;
    in_scene_is_empty = it.scene_is_empty;
    in_opponent_detected = it.opponent_detected;
    in_opponent_distance = it.opponent_distance;
    in_lane_is_lost = it.lane_is_lost;
    in_pose_x = it.pose_x;
    in_pose_y = it.pose_y;
    in_linear_speed = it.linear_speed;
    in_turn_rate = it.turn_rate;
    do @(posedge clk); while (!in_ready);
    sb.take_item(it);
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending_count() > 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [rss_pkg::TMO_BITS-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic run_random(int count, int check_pct);
    repeat (count) send_item(random_item(check_pct));
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_operation = rss_pkg::OP_TICK;
    in_scene_is_empty = 1'b0;
    in_opponent_detected = 1'b0;
    in_opponent_distance = '0;
    in_lane_is_lost = 1'b0;
    in_pose_x = '0;
    in_pose_y = '0;
    in_linear_speed = '0;
    in_turn_rate = '0;
    out_ready = 1'b0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    send_idle_pct = 38;
    recv_idle_pct = 75;
    // no scene yet, then the emergency boundary, empty scene and speed thresholds
    send_item(item_of(rss_pkg::OP_CHECK, 0, 1, 0, 1, 0, 0, 0, 0));
    send_item(item_of(rss_pkg::OP_CMD, 0, 0, 0, 0, 0, 0, 2, 0));
    send_item(item_of(rss_pkg::OP_CHECK, 0, 0, 0, 0, 0, 0, 0, 0));
    send_item(item_of(rss_pkg::OP_SCENE, 0, 1, 0, 1, 8388607, -8388608, 0, 0));
    send_item(item_of(rss_pkg::OP_CHECK, 0, 0, 0, 0, 0, 0, 0, 0));
    send_item(item_of(rss_pkg::OP_SCENE, 0, 1, 149, 1, -8388608, 8388607, 0, 0));
    send_item(item_of(rss_pkg::OP_CHECK, 0, 0, 0, 0, 0, 0, 0, 0));
    send_item(item_of(rss_pkg::OP_SCENE, 0, 1, 150, 0, 0, 0, 0, 0));
    send_item(item_of(rss_pkg::OP_CHECK, 0, 0, 0, 0, 0, 0, 0, 0));
    send_item(item_of(rss_pkg::OP_CHECK, 0, 0, 0, 0, 0, 0, 0, 0));
    send_item(item_of(rss_pkg::OP_SCENE, 1, 1, 0, 1, 5, 5, 0, 0));
    send_item(item_of(rss_pkg::OP_CHECK, 0, 0, 0, 0, 0, 0, 0, 0));
    send_item(item_of(rss_pkg::OP_CMD, 0, 0, 0, 0, 0, 0, 1, 10));
    send_item(item_of(rss_pkg::OP_CMD, 0, 0, 0, 0, 0, 0, -2, -11));
    send_item(item_of(rss_pkg::OP_CMD, 0, 0, 0, 0, 0, 0, -1048576, 1048575));
    settle();

    write_reg(rss_pkg::CFG_EMERG_DIST, 24'hFFFFFF);
    write_reg(rss_pkg::CFG_STUCK_TMO, 24'd0);
    write_reg(rss_pkg::CFG_LANE_TMO, 24'd0);
    write_reg(rss_pkg::CFG_SCENE_TMO, 24'd0);
    // zero timeouts: lane first loss, a 25 square move that does not count, all four events
    send_item(item_of(rss_pkg::OP_SCENE, 0, 1, 999000, 1, 0, 0, 0, 0));
    send_item(item_of(rss_pkg::OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0));
    send_item(item_of(rss_pkg::OP_CHECK, 0, 0, 0, 0, 0, 0, 0, 0));
    send_item(item_of(rss_pkg::OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0));
    send_item(item_of(rss_pkg::OP_SCENE, 0, 0, 0, 1, 3, 4, 0, 0));
    send_item(item_of(rss_pkg::OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0));
    send_item(item_of(rss_pkg::OP_CHECK, 0, 0, 0, 0, 0, 0, 0, 0));
    send_item(item_of(rss_pkg::OP_SCENE, 0, 1, 5, 1, 6, 9, 0, 0));
    send_item(item_of(rss_pkg::OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0));
    send_item(item_of(rss_pkg::OP_CHECK, 0, 0, 0, 0, 0, 0, 0, 0));
    send_item(item_of(rss_pkg::OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0));
    send_item(item_of(rss_pkg::OP_CHECK, 0, 0, 0, 0, 0, 0, 0, 0));
    settle();

    write_reg(rss_pkg::CFG_EMERG_DIST, rss_pkg::TMO_BITS'($urandom_range(2000)));
    write_reg(rss_pkg::CFG_STUCK_TMO, rss_pkg::TMO_BITS'($urandom_range(15)));
    write_reg(rss_pkg::CFG_LANE_TMO, 24'hFFFFFF);
    write_reg(rss_pkg::CFG_SCENE_TMO, rss_pkg::TMO_BITS'($urandom_range(20)));
    run_random(160, 25);
    settle();

    send_idle_pct = 75;
    recv_idle_pct = 38;
    write_reg(rss_pkg::CFG_EMERG_DIST, 24'd0);
    write_reg(rss_pkg::CFG_STUCK_TMO, rss_pkg::TMO_BITS'($urandom_range(10)));
    write_reg(rss_pkg::CFG_LANE_TMO, rss_pkg::TMO_BITS'($urandom_range(1, 8)));
    write_reg(rss_pkg::CFG_SCENE_TMO, 24'hFFFFFF);
    run_random(160, 25);
    settle();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(rss_pkg::CFG_EMERG_DIST, 24'hFFFFFF);
    write_reg(rss_pkg::CFG_STUCK_TMO, 24'hFFFFFF);
    write_reg(rss_pkg::CFG_LANE_TMO, 24'd0);
    write_reg(rss_pkg::CFG_SCENE_TMO, 24'd0);
    run_random(80, 25);
    hold_go = 1;
    run_random(40, 60);
    run_random(40, 25);
    settle();
    repeat (10) @(negedge clk);

    sb.leftover_check();
    $display("run: %0d items, %0d checks, %0d events, %0d register writes",
             sb.items, sb.checks, sb.events, sb.writes);
    $display("phases: reset settings, zero and full-scale limits, idling both ways, long stall");
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== files.f =====
sv/rss_pkg.sv
sv/rss_core.sv
sv/rss_evq.sv
sv/robot_safety_supervisor.sv
sv/rss_checker.sv
test/robot_safety_supervisor_tb.sv
